FILE: rtl/pac_pkg.sv
// Shared types and constants for the PID controller with filtered derivative
// and anti-windup. No dependencies; every other file of the block depends on it.
package pac_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned LIMIT_W      = 31;
  localparam int unsigned COEF_W       = 17;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned Q_FULL_SHIFT = 30;
  localparam int unsigned MUL_A_W      = 34;
  localparam int unsigned MUL_B_W      = 32;
  localparam int unsigned PROD_W       = 65;

  localparam logic [COEF_W-1:0] COEF_ONE      = 17'h10000;
  localparam logic [DATA_W-1:0] KP_GAIN_RESET = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN       = 3'd0,
    REG_D_GAIN        = 3'd1,
    REG_D_FILTER_COEF = 3'd2,
    REG_I_GAIN        = 3'd3,
    REG_OUTPUT_LIMIT  = 3'd4,
    REG_LOOP_ENABLE   = 3'd5,
    REG_OPEN_LOOP     = 3'd6
  } cfg_reg_t;

  // Datapath commands, one per sequencer step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_CLAMP_P,
    OP_DIFF,
    OP_MUL_F,
    OP_FILT,
    OP_MUL_D,
    OP_PD,
    OP_SUM,
    OP_MUL_I,
    OP_ACC
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_CLAMP_P,
    ST_DIFF,
    ST_MUL_F,
    ST_FILT,
    ST_MUL_D,
    ST_PD,
    ST_SUM,
    ST_MUL_I,
    ST_ACC
  } state_t;

endpackage

FILE: rtl/pac_if.sv
// Handshake channel interfaces of the PID controller: input items, result
// items and configuration writes. Depends on pac_pkg for widths.
interface pac_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pac_pkg::DATA_W-1:0] error_in;
  logic signed [pac_pkg::DATA_W-1:0] add_in;
  logic                              add_present;
  logic                              intg_set;
  logic                              intg_hold;
  logic signed [pac_pkg::DATA_W-1:0] preset_value;

  modport source(output valid, error_in, add_in, add_present, intg_set, intg_hold,
                 preset_value, input ready);
  modport sink(input valid, error_in, add_in, add_present, intg_set, intg_hold,
               preset_value, output ready);
endinterface

interface pac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pac_pkg::DATA_W-1:0] drive_out;
  logic signed [pac_pkg::DATA_W-1:0] integrator_out;

  modport source(output valid, drive_out, integrator_out, input ready);
  modport sink(input valid, drive_out, integrator_out, output ready);
endinterface

interface pac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pac_pkg::CFG_IDX_W-1:0]  index;
  logic [pac_pkg::DATA_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/pac_ctrl.sv
// Sequencer of the PID controller: steps the datapath through one item and
// owns the input and output handshakes. Depends on pac_pkg.
module pac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pac_pkg::dp_op_t op
);
  import pac_pkg::*;

  state_t state, state_next;
  logic   out_free;

  // The result register may be refilled once its item is taken.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_ACC) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        op         = OP_MUL_P;
        state_next = ST_CLAMP_P;
      end
      ST_CLAMP_P: begin
        op         = OP_CLAMP_P;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        op         = OP_DIFF;
        state_next = ST_MUL_F;
      end
      ST_MUL_F: begin
        op         = OP_MUL_F;
        state_next = ST_FILT;
      end
      ST_FILT: begin
        op         = OP_FILT;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        op         = OP_MUL_D;
        state_next = ST_PD;
      end
      ST_PD: begin
        op         = OP_PD;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        op         = OP_SUM;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        op         = OP_MUL_I;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (out_free) begin
          op         = OP_ACC;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pac_datapath.sv
// Datapath of the PID controller: configuration registers, loop state and one
// shared sign-magnitude multiplier driven by the sequencer. Depends on pac_pkg.
module pac_datapath #(
  parameter int unsigned FULL_SCALE_SHIFT = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pac_pkg::dp_op_t                   op,
  input  logic                              cfg_we,
  input  logic [pac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pac_pkg::DATA_W-1:0]        cfg_data,
  input  logic signed [pac_pkg::DATA_W-1:0] error_in,
  input  logic signed [pac_pkg::DATA_W-1:0] add_in,
  input  logic                              add_present,
  input  logic                              intg_set,
  input  logic                              intg_hold,
  input  logic signed [pac_pkg::DATA_W-1:0] preset_value,
  output logic signed [pac_pkg::DATA_W-1:0] drive_out,
  output logic signed [pac_pkg::DATA_W-1:0] integrator_out
);
  import pac_pkg::*;

  localparam int unsigned Q_SHIFT = Q_FULL_SHIFT - FULL_SCALE_SHIFT;
  localparam logic [LIMIT_W-1:0] Y_FULL = LIMIT_W'(64'd1 << FULL_SCALE_SHIFT);

  // Configuration.
  logic [DATA_W-1:0]  kp_gain;
  logic [DATA_W-1:0]  d_gain;
  logic [COEF_W-1:0]  d_coef;
  logic [DATA_W-1:0]  i_gain;
  logic [LIMIT_W-1:0] out_limit;
  logic               loop_en;
  logic               open_loop;

  // Item held for the duration of its computation.
  logic signed [31:0] err_r;
  logic signed [31:0] add_r;
  logic               add_ok;
  logic               set_r;
  logic               no_intg;
  logic signed [31:0] preset_r;

  // Loop state.
  logic signed [31:0] prev_prop;
  logic signed [32:0] deriv_filter;
  logic signed [63:0] integrator;
  logic signed [31:0] integ_shown;
  logic signed [31:0] last_drive;

  // Intermediate results.
  logic [PROD_W-1:0]  prod;
  logic               prod_neg;
  logic signed [31:0] p_r;
  logic signed [33:0] diff_r;
  logic signed [31:0] pd_r;
  logic signed [31:0] yi_r;
  logic signed [31:0] grow_r;
  logic signed [31:0] out_integ;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_A_W-1:0]        a_mag;
  logic [PROD_W-1:0]         mul_p;

  logic signed [32:0] lim_s;
  logic signed [32:0] limq_s;
  logic [48:0]        q_mag;
  logic [LIMIT_W-1:0] p_mag;
  logic signed [31:0] p_val;
  logic signed [34:0] f_delta;
  logic signed [34:0] df_sum;
  logic signed [49:0] d_term;
  logic signed [50:0] pd_sum;
  logic signed [31:0] pd_val;
  logic signed [31:0] hi;
  logic signed [31:0] pd32;
  logic signed [31:0] p32;
  logic signed [33:0] y_sum;
  logic signed [34:0] g_raw;
  logic signed [31:0] g_sat;
  logic signed [31:0] yi_val;
  logic               y_limited;
  logic signed [64:0] xd;
  logic signed [64:0] i_sum;
  logic signed [63:0] i_sat;
  logic signed [31:0] y_y;
  logic signed [31:0] add_v;
  logic signed [32:0] d_sum;
  logic signed [31:0] d_sat;
  logic signed [32:0] pre_w;
  logic signed [32:0] pre_cl;
  logic signed [31:0] pre_q;
  logic [LIMIT_W-1:0] cfg_lim;
  logic signed [32:0] cfg_limq;
  logic [COEF_W-1:0]  cfg_coef;

  assign lim_s  = $signed({2'b00, out_limit});
  assign limq_s = lim_s <<< Q_SHIFT;

  // Shared multiplier: magnitude of a signed operand times an unsigned one.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_P: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = kp_gain;
      end
      OP_MUL_F: begin
        mul_a = diff_r;
        mul_b = MUL_B_W'(d_coef);
      end
      OP_MUL_D: begin
        mul_a = MUL_A_W'(deriv_filter);
        mul_b = d_gain;
      end
      OP_MUL_I: begin
        mul_a = MUL_A_W'(grow_r);
        mul_b = i_gain;
      end
      default: begin
      end
    endcase
  end

  assign a_mag = mul_a[MUL_A_W-1] ? MUL_A_W'(-mul_a) : MUL_A_W'(mul_a);
  assign mul_p = PROD_W'(a_mag[MUL_A_W-2:0]) * PROD_W'(mul_b);

  // Proportional term, truncated toward zero and clamped to the limit.
  assign q_mag = prod[PROD_W-1:FRAC_W];
  assign p_mag = (q_mag > 49'(out_limit)) ? out_limit : q_mag[LIMIT_W-1:0];
  assign p_val = prod_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

  // Derivative filter step.
  assign f_delta = prod_neg ? -$signed({2'b00, prod[48:FRAC_W]})
                            : $signed({2'b00, prod[48:FRAC_W]});
  assign df_sum  = 35'(deriv_filter) + f_delta;

  // P plus D, clamped to the limit.
  assign d_term = prod_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign pd_sum = 51'(p_r) + 51'(d_term);
  always_comb begin
    if (pd_sum > 51'(lim_s)) begin
      pd_val = 32'(lim_s);
    end else if (pd_sum < -51'(lim_s)) begin
      pd_val = 32'(-lim_s);
    end else begin
      pd_val = pd_sum[31:0];
    end
  end

  // Limited sum and integrator growth.
  assign hi    = integrator[63:32];
  assign pd32  = pd_r <<< Q_SHIFT;
  assign p32   = p_r <<< Q_SHIFT;
  assign y_sum = 34'(pd32) + 34'(hi);
  always_comb begin
    y_limited = 1'b1;
    if (y_sum > 34'(limq_s)) begin
      yi_val = 32'(limq_s);
      g_raw  = 35'(limq_s) - 35'(y_sum);
    end else if (y_sum < -34'(limq_s)) begin
      yi_val = 32'(-limq_s);
      g_raw  = -35'(limq_s) - 35'(y_sum);
    end else begin
      y_limited = 1'b0;
      yi_val    = y_sum[31:0];
      g_raw     = no_intg ? '0 : 35'(p32);
    end
    if (g_raw > 35'sh0_7FFF_FFFF) begin
      g_sat = 32'sh7FFF_FFFF;
    end else if (g_raw < -35'sh0_8000_0000) begin
      g_sat = -32'sh8000_0000;
    end else begin
      g_sat = g_raw[31:0];
    end
  end

  // Integrator accumulate with 64-bit saturation.
  assign xd    = prod_neg ? -$signed({1'b0, prod[63:0]}) : $signed({1'b0, prod[63:0]});
  assign i_sum = 65'(integrator) + xd;
  always_comb begin
    if (i_sum[64] != i_sum[63]) begin
      i_sat = i_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      i_sat = i_sum[63:0];
    end
  end

  // Drive value in external units.
  assign y_y   = yi_r >>> Q_SHIFT;
  assign add_v = add_ok ? add_r : '0;
  assign d_sum = 33'(y_y) + 33'(add_v);
  always_comb begin
    if (d_sum[32] != d_sum[31]) begin
      d_sat = d_sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      d_sat = d_sum[31:0];
    end
  end

  // Integrator preset, clamped to the limit.
  assign pre_w = 33'(preset_r);
  always_comb begin
    if (pre_w > lim_s) begin
      pre_cl = lim_s;
    end else if (pre_w < -lim_s) begin
      pre_cl = -lim_s;
    end else begin
      pre_cl = pre_w;
    end
  end
  assign pre_q = 32'(pre_cl <<< Q_SHIFT);

  assign cfg_lim  = (cfg_data[LIMIT_W-1:0] > Y_FULL) ? Y_FULL : cfg_data[LIMIT_W-1:0];
  assign cfg_limq = $signed({2'b00, cfg_lim}) <<< Q_SHIFT;
  assign cfg_coef = (cfg_data[COEF_W-1:0] > COEF_ONE) ? COEF_ONE : cfg_data[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= KP_GAIN_RESET;
      d_gain       <= '0;
      d_coef       <= COEF_ONE;
      i_gain       <= '0;
      out_limit    <= Y_FULL;
      loop_en      <= 1'b1;
      open_loop    <= 1'b0;
      prev_prop    <= '0;
      deriv_filter <= '0;
      integrator   <= '0;
      integ_shown  <= '0;
      last_drive   <= '0;
      out_integ    <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          err_r    <= error_in;
          add_r    <= add_in;
          add_ok   <= add_present;
          set_r    <= intg_set;
          no_intg  <= intg_set || intg_hold;
          preset_r <= preset_value;
        end
        OP_MUL_P: begin
          prod     <= mul_p;
          prod_neg <= mul_a[MUL_A_W-1];
          if (set_r) begin
            integ_shown <= pre_q;
            integrator  <= {pre_q, 32'b0};
          end
        end
        OP_CLAMP_P: begin
          p_r <= p_val;
        end
        OP_DIFF: begin
          diff_r <= 34'(p_r) - 34'(prev_prop) - 34'(deriv_filter);
        end
        OP_MUL_F, OP_MUL_D, OP_MUL_I: begin
          prod     <= mul_p;
          prod_neg <= mul_a[MUL_A_W-1];
        end
        OP_FILT: begin
          deriv_filter <= loop_en ? df_sum[32:0] : '0;
          prev_prop    <= p_r;
        end
        OP_PD: begin
          pd_r <= pd_val;
        end
        OP_SUM: begin
          yi_r   <= loop_en ? yi_val : '0;
          grow_r <= g_sat;
          if (loop_en && !y_limited && !no_intg) begin
            integ_shown <= hi;
          end
        end
        OP_ACC: begin
          integrator <= loop_en ? i_sat : '0;
          if (open_loop) begin
            if (add_ok) begin
              last_drive <= add_r;
            end
          end else begin
            last_drive <= d_sat;
          end
          out_integ <= integ_shown >>> Q_SHIFT;
        end
        default: begin
        end
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          REG_KP_GAIN:       kp_gain <= cfg_data;
          REG_D_GAIN:        d_gain  <= cfg_data;
          REG_D_FILTER_COEF: d_coef  <= cfg_coef;
          REG_I_GAIN:        i_gain  <= cfg_data;
          REG_OUTPUT_LIMIT: begin
            out_limit <= cfg_lim;
            // Pull a visible integrator that lies outside the new limit back onto it.
            if (33'(integ_shown) > cfg_limq) begin
              integ_shown <= 32'(cfg_limq);
              integrator  <= {32'(cfg_limq), 32'b0};
            end else if (33'(integ_shown) < -cfg_limq) begin
              integ_shown <= 32'(-cfg_limq);
              integrator  <= {32'(-cfg_limq), 32'b0};
            end
          end
          REG_LOOP_ENABLE:   loop_en   <= cfg_data[0];
          REG_OPEN_LOOP:     open_loop <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  assign drive_out      = last_drive;
  assign integrator_out = out_integ;

endmodule

FILE: rtl/pid_controller_antiwindup_top.sv
// PID controller with filtered derivative and anti-windup, fixed point.
// Items are processed one at a time through the sequencer steps, the single shared multiplier
// being used four times per item; a new item is accepted only in the idle state.
// The next item is accepted while a finished result waits; its last step stalls until taken.
// Synchronous reset clears the loop state and loads default configuration.
// Depends on pac_pkg, pac_if, pac_ctrl and pac_datapath.
module pid_controller_antiwindup_top #(
  parameter int unsigned FULL_SCALE_SHIFT = 30
) (
  input logic       clk,
  input logic       rst,
  pac_in_if.sink    item_in,
  pac_out_if.source item_out,
  pac_cfg_if.sink   cfg
);
  import pac_pkg::*;

  dp_op_t op;

  assign cfg.ready = 1'b1;

  pac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (item_out.valid),
    .out_ready (item_out.ready),
    .op        (op)
  );

  pac_datapath #(
    .FULL_SCALE_SHIFT (FULL_SCALE_SHIFT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .error_in       (item_in.error_in),
    .add_in         (item_in.add_in),
    .add_present    (item_in.add_present),
    .intg_set       (item_in.intg_set),
    .intg_hold      (item_in.intg_hold),
    .preset_value   (item_in.preset_value),
    .drive_out      (item_out.drive_out),
    .integrator_out (item_out.integrator_out)
  );

endmodule
